### sv/gbfs_pkg.sv
// ----------------------------------------------------------------------------
// Graph reachability search package
// Shared constants and the command and status bundles that pass between the
// search controller and its datapath.
// ----------------------------------------------------------------------------
package gbfs_pkg;

	localparam int NODES_DEF = 16;
	localparam int FIELD_W   = 4;

	localparam logic FUNC_ADD   = 1'b0;
	localparam logic FUNC_QUERY = 1'b1;

	typedef struct packed {
		logic load;
		logic init;
		logic add_a;
		logic add_b;
		logic pop;
		logic fetch;
		logic row;
		logic drain;
		logic emit;
		logic emit_val;
	} gbfs_cmd_t;

	typedef struct packed {
		logic is_query;
		logic in_range;
		logic q_empty;
		logic hit;
		logic new_empty;
	} gbfs_sts_t;

endpackage

### sv/gbfs_dp.sv
// ----------------------------------------------------------------------------
// Graph reachability search datapath
// Holds the adjacency matrix with per-row valid bits, the visited mask, the
// node queue with its head and tail pointers, and the result register.
// ----------------------------------------------------------------------------
module gbfs_dp import gbfs_pkg::*; #(
	parameter int NODES = NODES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               func,
	input  logic [FIELD_W-1:0] node_a,
	input  logic [FIELD_W-1:0] node_b,
	input  gbfs_cmd_t          cmd_i,
	output gbfs_sts_t          sts_o,
	output logic               done,
	output logic               connected
);

	localparam int NW = $clog2(NODES);
	localparam int CW = $clog2(NODES + 1);
	localparam logic [NODES-1:0] ONE = NODES'(1);

	logic              func_q;
	logic [NW-1:0]     src_q;
	logic [NW-1:0]     dst_q;
	logic              rng_q;
	logic [CW-1:0]     head_q;
	logic [CW-1:0]     tail_q;
	logic [NODES-1:0]  visited_q;
	logic [NODES-1:0]  new_q;
	logic [NODES-1:0]  row_vld_q;
	logic [NODES-1:0]  adj_mem_q [NODES];
	logic [NODES-1:0]  adj_rd_q;
	logic              adj_rd_vld_q;
	logic [NW-1:0]     que_mem_q [NODES];
	logic [NW-1:0]     que_rd_q;
	logic              done_q;
	logic              connected_q;

	logic              adj_we;
	logic [NW-1:0]     adj_wr_row;
	logic [NW-1:0]     adj_wr_col;
	logic [NODES-1:0]  row_eff;
	logic [NODES-1:0]  new_low;
	logic [NW-1:0]     low_idx;
	logic              que_we;
	logic [NW-1:0]     que_wr_addr;
	logic [NW-1:0]     que_wr_data;

	assign adj_we     = cmd_i.add_a | cmd_i.add_b;
	assign adj_wr_row = cmd_i.add_a ? src_q : dst_q;
	assign adj_wr_col = cmd_i.add_a ? dst_q : src_q;
	assign row_eff    = adj_rd_vld_q ? adj_rd_q : '0;
	assign new_low    = new_q & (~new_q + ONE);

	always_comb begin
		low_idx = '0;
		for (int i = 0; i < NODES; i++) begin
			if (new_low[i]) begin
				low_idx = low_idx | NW'(i);
			end
		end
	end

	assign que_we      = cmd_i.init | (cmd_i.drain & (new_q != '0));
	assign que_wr_addr = cmd_i.init ? '0 : tail_q[NW-1:0];
	assign que_wr_data = cmd_i.init ? src_q : low_idx;

	always_ff @(posedge clk) begin
		if (cmd_i.load) begin
			func_q <= func;
			src_q  <= NW'(node_a);
			dst_q  <= NW'(node_b);
			rng_q  <= (32'(node_a) < NODES) && (32'(node_b) < NODES);
		end
	end

	always_ff @(posedge clk) begin
		if (adj_we) begin
			if (row_vld_q[adj_wr_row]) begin
				adj_mem_q[adj_wr_row][adj_wr_col] <= 1'b1;
			end else begin
				adj_mem_q[adj_wr_row] <= ONE << adj_wr_col;
			end
		end
		if (cmd_i.fetch) begin
			adj_rd_q <= adj_mem_q[que_rd_q];
		end
	end

	always_ff @(posedge clk) begin
		if (que_we) begin
			que_mem_q[que_wr_addr] <= que_wr_data;
		end
		if (cmd_i.pop) begin
			que_rd_q <= que_mem_q[head_q[NW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q    <= '0;
			adj_rd_vld_q <= 1'b0;
			head_q       <= '0;
			tail_q       <= '0;
			visited_q    <= '0;
			new_q        <= '0;
			done_q       <= 1'b0;
			connected_q  <= 1'b0;
		end else begin
			if (adj_we) begin
				row_vld_q[adj_wr_row] <= 1'b1;
			end
			if (cmd_i.fetch) begin
				adj_rd_vld_q <= row_vld_q[que_rd_q];
			end
			if (cmd_i.init) begin
				head_q    <= '0;
				tail_q    <= CW'(1);
				visited_q <= ONE << src_q;
			end
			if (cmd_i.pop) begin
				head_q <= head_q + CW'(1);
			end
			if (cmd_i.row) begin
				visited_q <= visited_q | row_eff;
				new_q     <= row_eff & ~visited_q;
			end
			if (cmd_i.drain && new_q != '0) begin
				tail_q <= tail_q + CW'(1);
				new_q  <= new_q & ~new_low;
			end
			if (cmd_i.emit) begin
				visited_q <= '0;
			end
			done_q      <= cmd_i.emit;
			connected_q <= cmd_i.emit ? cmd_i.emit_val : 1'b0;
		end
	end

	assign sts_o.is_query  = (func_q == FUNC_QUERY);
	assign sts_o.in_range  = rng_q;
	assign sts_o.q_empty   = (head_q == tail_q);
	assign sts_o.hit       = (que_rd_q == dst_q);
	assign sts_o.new_empty = (new_q == '0);

	assign done      = done_q;
	assign connected = connected_q;

	a_tail_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(tail_q) <= NODES)
		else $error("Queue tail has passed the node count.");

	a_head_tail: assert property (@(posedge clk) disable iff (!arst_n)
		head_q <= tail_q)
		else $error("Queue head has overtaken the tail.");

	a_new_visited: assert property (@(posedge clk) disable iff (!arst_n)
		(new_q & ~visited_q) == '0)
		else $error("A pending neighbour is not marked as visited.");

	a_visited_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_i.emit |=> visited_q == '0)
		else $error("Visited mask not cleared after a query.");

endmodule

### sv/gbfs_ctrl.sv
// ----------------------------------------------------------------------------
// Graph reachability search controller
// One-hot state machine that sequences edge insertion and the breadth-first
// search over the datapath.
// ----------------------------------------------------------------------------
module gbfs_ctrl import gbfs_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  gbfs_sts_t sts_i,
	output gbfs_cmd_t cmd_o,
	output logic      busy
);

	typedef enum logic [7:0] {
		S_IDLE   = 8'b0000_0001,
		S_DECODE = 8'b0000_0010,
		S_ADD_A  = 8'b0000_0100,
		S_ADD_B  = 8'b0000_1000,
		S_POP    = 8'b0001_0000,
		S_FETCH  = 8'b0010_0000,
		S_ROW    = 8'b0100_0000,
		S_DRAIN  = 8'b1000_0000
	} gbfs_state_t;

	gbfs_state_t state_q;
	gbfs_state_t state_nxt;

	always_comb begin
		cmd_o     = '0;
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd_o.load = 1'b1;
					state_nxt  = S_DECODE;
				end
			end
			S_DECODE: begin
				if (!sts_i.is_query) begin
					state_nxt = sts_i.in_range ? S_ADD_A : S_IDLE;
				end else if (!sts_i.in_range) begin
					cmd_o.emit     = 1'b1;
					cmd_o.emit_val = 1'b0;
					state_nxt      = S_IDLE;
				end else begin
					cmd_o.init = 1'b1;
					state_nxt  = S_POP;
				end
			end
			S_ADD_A: begin
				cmd_o.add_a = 1'b1;
				state_nxt   = S_ADD_B;
			end
			S_ADD_B: begin
				cmd_o.add_b = 1'b1;
				state_nxt   = S_IDLE;
			end
			S_POP: begin
				if (sts_i.q_empty) begin
					cmd_o.emit     = 1'b1;
					cmd_o.emit_val = 1'b0;
					state_nxt      = S_IDLE;
				end else begin
					cmd_o.pop = 1'b1;
					state_nxt = S_FETCH;
				end
			end
			S_FETCH: begin
				if (sts_i.hit) begin
					cmd_o.emit     = 1'b1;
					cmd_o.emit_val = 1'b1;
					state_nxt      = S_IDLE;
				end else begin
					cmd_o.fetch = 1'b1;
					state_nxt   = S_ROW;
				end
			end
			S_ROW: begin
				cmd_o.row = 1'b1;
				state_nxt = S_DRAIN;
			end
			S_DRAIN: begin
				if (sts_i.new_empty) begin
					state_nxt = S_POP;
				end else begin
					cmd_o.drain = 1'b1;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	assign busy = (state_q != S_IDLE);

endmodule

### sv/graph_reachability_bfs_unit.sv
// ----------------------------------------------------------------------------
// Graph reachability unit
// Keeps an undirected graph as an adjacency bit matrix and answers whether
// one node can be reached from another by breadth-first search.
//
// A command is transferred on a rising edge where start is high and busy is
// low; func, node_a and node_b are sampled on that edge. An add command
// (func low) sets the edge in both directions if both nodes are in range
// and gives no result; it keeps busy high through decode and the two row
// writes. A query (func high) gives one result: done is high for exactly
// one cycle with connected valid beside it; the receiver cannot hold it off.
// A query decodes, then for every node taken from the queue reads the queue,
// reads the adjacency row and updates the masks, then appends each newly
// found neighbour to the queue, one per step, and closes the scan in a last
// step; the search ends when the node read from the queue is the target or
// the queue is empty. Done rises on the same edge at which busy falls. The
// search speed is set by the single read port of the adjacency and queue memories.
// Reset clears the graph, the visited mask and the controller; the queue
// contents are not cleared.
// ----------------------------------------------------------------------------
module graph_reachability_bfs_unit import gbfs_pkg::*; #(
	parameter int NODES = NODES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               func,
	input  logic [FIELD_W-1:0] node_a,
	input  logic [FIELD_W-1:0] node_b,
	output logic               done,
	output logic               connected
);

	gbfs_cmd_t cmd;
	gbfs_sts_t sts;

	gbfs_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts_i  (sts),
		.cmd_o  (cmd),
		.busy   (busy)
	);

	gbfs_dp #(
		.NODES (NODES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.func      (func),
		.node_a    (node_a),
		.node_b    (node_b),
		.cmd_i     (cmd),
		.sts_o     (sts),
		.done      (done),
		.connected (connected)
	);

endmodule
